>>> hw/rtl/msor_pkg.sv
// Shared types and codes of the MP4 sample offset resolver.
`default_nettype none
package msor_pkg;

  typedef enum logic [1:0] {
    FN_MAP   = 2'd0,
    FN_SIZE  = 2'd1,
    FN_CHUNK = 2'd2,
    FN_END   = 2'd3
  } func_e_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_MAP   = 4'd1,
    ST_BAD_SIZE  = 4'd2,
    ST_MAP_LATE  = 4'd3,
    ST_OVER      = 4'd4,
    ST_BAD_OFF   = 4'd5,
    ST_OUTSIDE   = 4'd6,
    ST_UNCOVERED = 4'd7,
    ST_NO_MAP    = 4'd8
  } status_e_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_WALK_RD,
    S_WALK_CHK,
    S_ENTRY_RD,
    S_ENTRY_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT_RD,
    S_EMIT,
    S_RESP
  } state_e_t;

  localparam int unsigned REG_DEFAULT_SIZE = 0;
  localparam int unsigned REG_FILE_SIZE    = 1;
  localparam int unsigned REG_SAMPLE_COUNT = 2;

  typedef struct packed {
    logic      map_wr;
    logic      size_wr;
    logic      set_code;
    logic [3:0] code;
    logic      map_sel_next;
    logic      pos_inc;
    logic      scan_init;
    logic      scan_step;
    logic      emit_sample;
    logic      emit_single;
  } cmd_t;

  typedef struct packed {
    logic       error_hold;
    logic [3:0] held_code;
    logic [1:0] func;
    logic       map_bad;
    logic       size_bad;
    logic       map_empty;
    logic       count_bad;
    logic       covered;
    logic       walk_more;
    logic       walk_adv;
    logic       late;
    logic       run_bad;
    logic       off_bad;
    logic       sz_zero;
    logic       over_file;
    logic       scan_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/mp4_sample_offset_resolver.sv
// A load or check item passes S_EVAL and S_RESP on its way to the result register.
// A chunk item walks map entries (S_WALK_RD, S_WALK_CHK), range checks each sample (S_SCAN_RD,
// S_SCAN_CHK), then emits each one (S_EMIT_RD, S_EMIT); S_RESP and S_EMIT wait for out_free.
// One item is processed at a time; a result register lets the next item in.
// rst_n (synchronous) clears fill counts, walk state and the sticky error.
// Table contents are not cleared; fill counts mark which entries hold data.
`default_nettype none
module mp4_sample_offset_resolver #(
  parameter int MAP_DEPTH    = 16,
  parameter int SAMPLE_DEPTH = 4096,
  parameter int MAX_RUN      = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_chunk, per_chunk, desc_index, size_value, chunk_offset
  input  wire logic [191:0] in_tdata,
  // func
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // sample_offset, sample_bytes, sample_index, zero fill
  output logic [111:0]      out_tdata,
  output logic              out_tlast,
  // status
  output logic [3:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);
  logic [31:0] default_size_r;
  logic [62:0] file_size_r;
  logic [12:0] sample_count_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  msor_pkg::cmd_t     cmd;
  msor_pkg::sts_t     sts;
  msor_pkg::state_e_t state;
  logic [62:0] o_off;
  logic [31:0] o_bytes;
  logic [11:0] o_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_size_r <= '0;
      file_size_r    <= '0;
      sample_count_r <= 13'd1;
    end else if (cfg_wr && cfg_paddr[2:0] == 3'd0) begin
      if (32'(cfg_idx) == msor_pkg::REG_DEFAULT_SIZE) default_size_r <= cfg_pwdata[31:0];
      if (32'(cfg_idx) == msor_pkg::REG_FILE_SIZE) file_size_r <= cfg_pwdata[62:0];
      if (32'(cfg_idx) == msor_pkg::REG_SAMPLE_COUNT) sample_count_r <= cfg_pwdata[12:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      if (32'(cfg_idx) == msor_pkg::REG_DEFAULT_SIZE) cfg_prdata = 64'(default_size_r);
      if (32'(cfg_idx) == msor_pkg::REG_FILE_SIZE) cfg_prdata = 64'(file_size_r);
      if (32'(cfg_idx) == msor_pkg::REG_SAMPLE_COUNT) cfg_prdata = 64'(sample_count_r);
    end
  end

  msor_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .sts(sts), .cmd(cmd), .state(state)
  );

  msor_dp #(.MAP_DEPTH(MAP_DEPTH), .SAMPLE_DEPTH(SAMPLE_DEPTH), .MAX_RUN(MAX_RUN)) u_dp (
    .clk(clk), .rst_n(rst_n), .take(in_tvalid && in_tready),
    .in_func(in_tuser), .in_data(in_tdata),
    .default_size(default_size_r), .file_size(file_size_r),
    .sample_count(sample_count_r), .cmd(cmd), .sts(sts),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_offset(o_off), .out_bytes(o_bytes), .out_index(o_idx),
    .out_last(out_tlast), .out_status(out_tuser)
  );

  assign out_tdata = {5'd0, o_idx, o_bytes, o_off};

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.error_hold |=> sts.error_hold) else $error("sticky error cleared");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second item taken");
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser == msor_pkg::ST_OK))
    else $error("error inside a chunk");
  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sample |-> (state == msor_pkg::S_EMIT)) else $error("stray emit");
endmodule
`default_nettype wire

>>> hw/rtl/msor_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module msor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/msor_ctrl.sv
// Controller state machine of the sample offset resolver.
`default_nettype none
module msor_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire msor_pkg::sts_t sts,
  output msor_pkg::cmd_t     cmd,
  output msor_pkg::state_e_t state
);
  msor_pkg::state_e_t state_r, state_nxt;

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msor_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      msor_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = msor_pkg::S_EVAL;
        end
      end
      msor_pkg::S_EVAL: begin
        cmd.set_code = 1'b1;
        cmd.code     = msor_pkg::ST_OK;
        state_nxt    = msor_pkg::S_RESP;
        if (sts.error_hold) begin
          cmd.code = sts.held_code;
        end else begin
          unique case (sts.func)
            msor_pkg::FN_MAP: begin
              if (sts.map_bad) cmd.code = msor_pkg::ST_BAD_MAP;
              else cmd.map_wr = 1'b1;
            end
            msor_pkg::FN_SIZE: begin
              if (sts.size_bad) cmd.code = msor_pkg::ST_BAD_SIZE;
              else cmd.size_wr = 1'b1;
            end
            msor_pkg::FN_END: begin
              priority if (sts.map_empty) cmd.code = msor_pkg::ST_NO_MAP;
              else if (sts.count_bad) cmd.code = msor_pkg::ST_OVER;
              else if (!sts.covered) cmd.code = msor_pkg::ST_UNCOVERED;
              else cmd.code = msor_pkg::ST_OK;
            end
            default: begin
              priority if (sts.map_empty) cmd.code = msor_pkg::ST_NO_MAP;
              else if (sts.count_bad) cmd.code = msor_pkg::ST_OVER;
              else begin
                cmd.set_code = 1'b0;
                state_nxt    = msor_pkg::S_WALK_RD;
              end
            end
          endcase
        end
      end
      msor_pkg::S_WALK_RD: begin
        cmd.map_sel_next = 1'b1;
        state_nxt = sts.walk_more ? msor_pkg::S_WALK_CHK : msor_pkg::S_ENTRY_RD;
      end
      msor_pkg::S_WALK_CHK: begin
        cmd.map_sel_next = 1'b1;
        if (sts.walk_adv) begin
          cmd.pos_inc = 1'b1;
          state_nxt   = msor_pkg::S_WALK_RD;
        end else begin
          state_nxt = msor_pkg::S_ENTRY_RD;
        end
      end
      msor_pkg::S_ENTRY_RD: begin
        state_nxt = msor_pkg::S_ENTRY_CHK;
      end
      msor_pkg::S_ENTRY_CHK: begin
        cmd.set_code = 1'b1;
        state_nxt    = msor_pkg::S_RESP;
        priority if (sts.late) cmd.code = msor_pkg::ST_MAP_LATE;
        else if (sts.run_bad) cmd.code = msor_pkg::ST_OVER;
        else if (sts.off_bad) cmd.code = msor_pkg::ST_BAD_OFF;
        else begin
          cmd.set_code  = 1'b0;
          cmd.scan_init = 1'b1;
          state_nxt     = msor_pkg::S_SCAN_RD;
        end
      end
      msor_pkg::S_SCAN_RD: begin
        state_nxt = msor_pkg::S_SCAN_CHK;
      end
      msor_pkg::S_SCAN_CHK: begin
        priority if (sts.sz_zero) begin
          cmd.set_code = 1'b1;
          cmd.code     = msor_pkg::ST_BAD_SIZE;
          state_nxt    = msor_pkg::S_RESP;
        end else if (sts.over_file) begin
          cmd.set_code = 1'b1;
          cmd.code     = msor_pkg::ST_OUTSIDE;
          state_nxt    = msor_pkg::S_RESP;
        end else if (sts.scan_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = msor_pkg::S_EMIT_RD;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = msor_pkg::S_SCAN_RD;
        end
      end
      msor_pkg::S_EMIT_RD: begin
        state_nxt = msor_pkg::S_EMIT;
      end
      msor_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_sample = 1'b1;
          state_nxt = sts.scan_last ? msor_pkg::S_IDLE : msor_pkg::S_EMIT_RD;
        end
      end
      msor_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = msor_pkg::S_IDLE;
        end
      end
      default: state_nxt = msor_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/msor_dp.sv
// Datapath of the sample offset resolver: tables, walk state, sums, result register.
`default_nettype none
module msor_dp #(
  parameter int MAP_DEPTH    = 16,
  parameter int SAMPLE_DEPTH = 4096,
  parameter int MAX_RUN      = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           take,
  input  wire logic [1:0]     in_func,
  input  wire logic [191:0]   in_data,
  input  wire logic [31:0]    default_size,
  input  wire logic [62:0]    file_size,
  input  wire logic [12:0]    sample_count,
  input  wire msor_pkg::cmd_t cmd,
  output msor_pkg::sts_t      sts,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [62:0]         out_offset,
  output logic [31:0]         out_bytes,
  output logic [11:0]         out_index,
  output logic                out_last,
  output logic [3:0]          out_status
);
  localparam int MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int MFW = $clog2(MAP_DEPTH + 1);
  localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int SFW = $clog2(SAMPLE_DEPTH + 1);

  logic [1:0]  func_r;
  logic [31:0] fc_r, pc_r, dc_r, sv_r;
  logic [63:0] off_r;
  logic [MFW-1:0] map_fill_r;
  logic [SFW-1:0] size_fill_r;
  logic [MAW-1:0] pos_r;
  logic [12:0] next_sample_r;
  logic [31:0] chunk_number_r, last_fc_r;
  logic        error_hold_r;
  logic [3:0]  held_code_r, code_r;
  logic [6:0]  i_r, count_r;
  logic [63:0] o_r;
  logic        out_valid_r;

  logic [MAW-1:0] map_raddr;
  logic [31:0] first_rd, run_rd, size_rd, sz, chunk;
  logic [16:0] idx;
  logic [63:0] o_sum;

  assign chunk     = chunk_number_r + 32'd1;
  assign map_raddr = cmd.map_sel_next ? pos_r + 1'b1 : pos_r;
  assign idx       = 17'(next_sample_r) + 17'(i_r);
  assign o_sum     = o_r + 64'(sz);

  always_comb begin
    if (default_size != 32'd0) sz = default_size;
    else if (idx < 17'(size_fill_r)) sz = size_rd;
    else sz = 32'd0;
  end

  msor_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_first (
    .clk(clk), .we(cmd.map_wr), .waddr(map_fill_r[MAW-1:0]), .wdata(fc_r),
    .raddr(map_raddr), .rdata(first_rd)
  );
  msor_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_run (
    .clk(clk), .we(cmd.map_wr), .waddr(map_fill_r[MAW-1:0]), .wdata(pc_r),
    .raddr(map_raddr), .rdata(run_rd)
  );
  msor_ram #(.WIDTH(32), .DEPTH(SAMPLE_DEPTH)) u_size (
    .clk(clk), .we(cmd.size_wr), .waddr(size_fill_r[SAW-1:0]), .wdata(sv_r),
    .raddr(idx[SAW-1:0]), .rdata(size_rd)
  );

  always_comb begin
    sts            = '0;
    sts.error_hold = error_hold_r;
    sts.held_code  = held_code_r;
    sts.func       = func_r;
    sts.map_bad    = (fc_r == 32'd0) || (pc_r == 32'd0) || (dc_r == 32'd0) ||
                     (pc_r > 32'(MAX_RUN)) || (map_fill_r == MFW'(MAP_DEPTH)) ||
                     ((map_fill_r != '0) && (fc_r <= last_fc_r));
    sts.size_bad   = (sv_r == 32'd0) || (size_fill_r == SFW'(SAMPLE_DEPTH));
    sts.map_empty  = (map_fill_r == '0);
    sts.count_bad  = (sample_count == 13'd0) || (32'(sample_count) > 32'(SAMPLE_DEPTH));
    sts.covered    = (next_sample_r == sample_count);
    sts.walk_more  = (17'(pos_r) + 17'd1) < 17'(map_fill_r);
    sts.walk_adv   = (first_rd <= chunk);
    sts.late       = (first_rd > chunk);
    sts.run_bad    = (run_rd == 32'd0) || (run_rd > 32'(MAX_RUN)) ||
                     ((33'(next_sample_r) + 33'(run_rd)) > 33'(sample_count));
    sts.off_bad    = off_r[63];
    sts.sz_zero    = (sz == 32'd0);
    sts.over_file  = o_sum > {1'b0, file_size};
    sts.scan_last  = (8'(i_r) + 8'd1) == 8'(count_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      func_r <= in_func;
      fc_r   <= in_data[31:0];
      pc_r   <= in_data[63:32];
      dc_r   <= in_data[95:64];
      sv_r   <= in_data[127:96];
      off_r  <= in_data[191:128];
    end
    if (cmd.map_wr) last_fc_r <= fc_r;
    if (cmd.set_code) code_r <= cmd.code;
    if (cmd.scan_init) begin
      i_r     <= 7'd0;
      o_r     <= off_r;
      count_r <= run_rd[6:0];
    end else if (cmd.scan_step || cmd.emit_sample) begin
      i_r <= i_r + 7'd1;
      o_r <= o_sum;
    end
    if (cmd.emit_sample) begin
      out_offset <= o_r[62:0];
      out_bytes  <= sz;
      out_index  <= idx[11:0];
      out_last   <= sts.scan_last;
      out_status <= msor_pkg::ST_OK;
    end else if (cmd.emit_single) begin
      out_offset <= '0;
      out_bytes  <= '0;
      out_index  <= '0;
      out_last   <= 1'b1;
      out_status <= code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_fill_r     <= '0;
      size_fill_r    <= '0;
      pos_r          <= '0;
      next_sample_r  <= '0;
      chunk_number_r <= '0;
      error_hold_r   <= 1'b0;
      held_code_r    <= msor_pkg::ST_OK;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.map_wr) map_fill_r <= map_fill_r + 1'b1;
      if (cmd.size_wr) size_fill_r <= size_fill_r + 1'b1;
      if (cmd.pos_inc) pos_r <= pos_r + 1'b1;
      if (cmd.emit_sample && sts.scan_last) begin
        next_sample_r  <= 13'(17'(next_sample_r) + 17'(count_r));
        chunk_number_r <= chunk;
      end
      if (cmd.emit_single && code_r != msor_pkg::ST_OK) begin
        error_hold_r <= 1'b1;
        held_code_r  <= code_r;
      end
      if (cmd.emit_sample || cmd.emit_single) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

>>> bench/mp4_sample_offset_checker.sv
// Scoreboard for the sample offset resolver: predicts every result and compares it.
module mp4_sample_offset_checker
  import msor_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  input  logic         out_tlast,
  input  logic [3:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           mismatches,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_DEPTH = 16;
  localparam int SAMPLE_DEPTH = 4096;
  localparam int MAX_RUN = 64;

  typedef struct packed {
    logic [62:0] offset;
    logic [31:0] bytes;
    logic [11:0] index;
    logic        last;
    status_e_t   status;
  } sample_rec_t;

  sample_rec_t expected_samples[$];

  logic [31:0] map_first[MAP_DEPTH];
  logic [31:0] map_run[MAP_DEPTH];
  logic [31:0] size_mem[SAMPLE_DEPTH];
  int          map_fill, size_fill, map_pos, next_sample;
  logic [31:0] chunk_no;
  bit          err_hold;
  status_e_t   held_status;
  logic [31:0] default_size;
  logic [62:0] file_size;
  logic [12:0] sample_count;
  int          fail_cnt;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic push(logic [62:0] off, logic [31:0] bytes, logic [11:0] idx, logic last,
                      status_e_t st);
    sample_rec_t r;
    r.offset = off;
    r.bytes = bytes;
    r.index = idx;
    r.last = last;
    r.status = st;
    expected_samples.push_back(r);
  endtask

  task automatic fail_with(status_e_t st);
    err_hold = 1'b1;
    held_status = st;
    push('0, '0, '0, 1'b1, st);
  endtask

  function automatic logic [31:0] size_for(int idx);
    if (default_size != 0) return default_size;
    if (idx < size_fill && idx < SAMPLE_DEPTH) return size_mem[idx];
    return '0;
  endfunction

  function automatic bit count_bad();
    return sample_count == 0 || sample_count > SAMPLE_DEPTH;
  endfunction

  task automatic predict(func_e_t fn, logic [191:0] d);
    logic [31:0] fc, pc, dc, sv, chunk, sz;
    logic [63:0] off, o;
    int pos, cnt;
    fc = d[31:0];
    pc = d[63:32];
    dc = d[95:64];
    sv = d[127:96];
    off = d[191:128];
    if (err_hold) begin
      push('0, '0, '0, 1'b1, held_status);
      return;
    end
    case (fn)
      FN_MAP: begin
        if (fc == 0 || pc == 0 || dc == 0 || pc > MAX_RUN || map_fill >= MAP_DEPTH ||
            (map_fill > 0 && fc <= map_first[map_fill-1])) begin
          fail_with(ST_BAD_MAP);
          return;
        end
        map_first[map_fill] = fc;
        map_run[map_fill] = pc;
        map_fill++;
        push('0, '0, '0, 1'b1, ST_OK);
      end
      FN_SIZE: begin
        if (sv == 0 || size_fill >= SAMPLE_DEPTH) begin
          fail_with(ST_BAD_SIZE);
          return;
        end
        size_mem[size_fill] = sv;
        size_fill++;
        push('0, '0, '0, 1'b1, ST_OK);
      end
      FN_END: begin
        if (map_fill == 0) fail_with(ST_NO_MAP);
        else if (count_bad()) fail_with(ST_OVER);
        else if (next_sample != sample_count) fail_with(ST_UNCOVERED);
        else push('0, '0, '0, 1'b1, ST_OK);
      end
      default: begin
        if (map_fill == 0) begin
          fail_with(ST_NO_MAP);
          return;
        end
        if (count_bad()) begin
          fail_with(ST_OVER);
          return;
        end
        chunk = chunk_no + 1;
        pos = (map_pos >= map_fill) ? map_fill - 1 : map_pos;
        while (pos + 1 < map_fill && map_first[pos+1] <= chunk) pos++;
        map_pos = pos;
        if (map_first[pos] > chunk) begin
          fail_with(ST_MAP_LATE);
          return;
        end
        cnt = map_run[pos];
        if (cnt == 0 || cnt > MAX_RUN || next_sample + cnt > sample_count) begin
          fail_with(ST_OVER);
          return;
        end
        if (off[63]) begin
          fail_with(ST_BAD_OFF);
          return;
        end
        // The whole chunk is range checked before any sample goes out.
        o = off;
        for (int i = 0; i < cnt; i++) begin
          sz = size_for(next_sample + i);
          if (sz == 0) begin
            fail_with(ST_BAD_SIZE);
            return;
          end
          if (o + sz > {1'b0, file_size}) begin
            fail_with(ST_OUTSIDE);
            return;
          end
          o = o + sz;
        end
        o = off;
        for (int i = 0; i < cnt; i++) begin
          sz = size_for(next_sample + i);
          push(o[62:0], sz, 12'(next_sample + i), i + 1 == cnt, ST_OK);
          o = o + sz;
        end
        next_sample += cnt;
        chunk_no = chunk;
      end
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    sample_rec_t e;
    if (!rst_n) begin
      expected_samples.delete();
      map_fill = 0;
      size_fill = 0;
      map_pos = 0;
      next_sample = 0;
      chunk_no = '0;
      err_hold = 1'b0;
      held_status = ST_OK;
      default_size = '0;
      file_size = '0;
      sample_count = 13'd1;
      fail_cnt = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (int'(cfg_paddr >> 3))
          REG_DEFAULT_SIZE: default_size = cfg_pwdata[31:0];
          REG_FILE_SIZE:    file_size = cfg_pwdata[62:0];
          REG_SAMPLE_COUNT: sample_count = cfg_pwdata[12:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict(func_e_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report("unexpected transaction", out_tdata[63:0], '0);
        end else begin
          e = expected_samples.pop_front();
          if (out_tdata[62:0] != e.offset) report("sample_offset", out_tdata[62:0], e.offset);
          if (out_tdata[94:63] != e.bytes) report("sample_bytes", out_tdata[94:63], e.bytes);
          if (out_tdata[106:95] != e.index) report("sample_index", out_tdata[106:95], e.index);
          if (out_tlast != e.last) report("last", out_tlast, e.last);
          if (out_tuser != e.status) report("status", out_tuser, e.status);
        end
      end
    end
    mismatches <= fail_cnt;
    pending <= expected_samples.size();
  end

endmodule

>>> bench/mp4_sample_offset_resolver_tb.sv
// Top of the resolver testbench: clock, reset, stimulus, flow control and verdict.
module mp4_sample_offset_resolver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msor_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic [62:0] FILE_MAX = {63{1'b1}};
  localparam logic [63:0] OFF_MARGIN = 64'd1 << 39;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // first_chunk, per_chunk, desc_index, size_value, chunk_offset
  logic [191:0] in_tdata = '0;
  // func
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // sample_offset, sample_bytes, sample_index, zero fill
  logic [111:0] out_tdata;
  logic         out_tlast;
  // status
  logic [3:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  int  mismatches, pending;
  int  cycles = 0;
  bit  tx_idle = 1'b0;
  bit  rx_stall = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  logic [31:0] map_fc[16];
  logic [31:0] map_pc[16];
  logic [31:0] chunk_no;
  int          used;
  logic [62:0] file_cur;

  mp4_sample_offset_resolver dut (.*);

  mp4_sample_offset_checker checker_i (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side flow control, including one long hold-off that fills the block.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_tready <= rx_stall ? ($urandom_range(99) >= 70) : 1'b1;
    end
  end

  task automatic set_idling(int mode);
    tx_idle <= (mode == 1 || mode == 3);
    rx_stall <= (mode == 2 || mode == 3);
  endtask

  task automatic send(func_e_t fn, logic [31:0] fc, logic [31:0] pc, logic [31:0] dc,
                      logic [31:0] sv, logic [63:0] off);
    while (tx_idle && $urandom_range(99) < 70) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {off, sv, dc, pc, fc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_noise(func_e_t fn, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] s, logic [63:0] off);
    send(fn, a, b, c, s, off);
  endtask

  task automatic cfg_write(int idx, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx * 8);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int run_of(logic [31:0] c);
    int r;
    r = 0;
    for (int i = 0; i < 16; i++) if (map_fc[i] <= c) r = map_pc[i];
    return r;
  endfunction

  function automatic logic [63:0] pick_offset();
    logic [63:0] r;
    r = {$urandom, $urandom};
    r[63] = 1'b0;
    return r % ({1'b0, file_cur} - OFF_MARGIN);
  endfunction

  // Sends chunk transactions until the quota or the sample budget runs out.
  task automatic run_chunks(int quota, int budget);
    int n;
    for (int k = 0; k < quota; k++) begin
      n = run_of(chunk_no + 1);
      if (used + n > budget) break;
      send(FN_CHUNK, $urandom, $urandom, $urandom, $urandom,
           k == 0 ? 64'd0 : (k == 1 ? {1'b0, file_cur} - OFF_MARGIN - 1 : pick_offset()));
      used += n;
      chunk_no++;
    end
    drain();
  endtask

  initial begin
    logic [31:0] sv;
    int kind;
    chunk_no = '0;
    used = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Loads only, so the extreme register values cannot trip any check here.
    set_idling($urandom_range(3));
    cfg_write(REG_DEFAULT_SIZE, 64'hFFFF_FFFF);
    cfg_write(REG_FILE_SIZE, 64'd0);
    cfg_write(REG_SAMPLE_COUNT, 64'd1);
    map_fc[0] = 32'd1;
    map_pc[0] = 32'd1;
    map_fc[1] = 32'd2;
    map_pc[1] = 32'd64;
    for (int i = 2; i < 15; i++) begin
      map_fc[i] = map_fc[i-1] + $urandom_range(1, 12);
      map_pc[i] = $urandom_range(1, 64);
    end
    map_fc[15] = 32'hFFFF_FFFF;
    map_pc[15] = $urandom_range(1, 64);
    for (int i = 0; i < 16; i++)
      send(FN_MAP, map_fc[i], map_pc[i],
           i == 0 ? 32'hFFFF_FFFF : ($urandom | 32'd1), $urandom, {$urandom, $urandom});
    for (int i = 0; i < 200; i++) begin
      case (i)
        0: sv = 32'd1;
        1: sv = 32'hFFFF_FFFF;
        2: sv = 32'h8000_0000;
        default: sv = ($urandom == 0) ? 32'd7 : $urandom;
      endcase
      send(FN_SIZE, $urandom, $urandom, $urandom, sv, {$urandom, $urandom});
    end
    drain();

    // Per-sample sizes from the loaded table.
    set_idling(0);
    file_cur = FILE_MAX;
    cfg_write(REG_DEFAULT_SIZE, 64'd0);
    cfg_write(REG_FILE_SIZE, {1'b0, file_cur});
    cfg_write(REG_SAMPLE_COUNT, 64'd4096);
    run_chunks(1000, 200);

    set_idling(1);
    file_cur = (63'd1 << 40) + {$urandom, $urandom} % (63'd1 << 50);
    cfg_write(REG_DEFAULT_SIZE, 64'd1);
    cfg_write(REG_FILE_SIZE, {1'b0, file_cur});
    run_chunks(40, 4096);

    set_idling(2);
    hold_go <= 1'b1;
    file_cur = FILE_MAX;
    cfg_write(REG_DEFAULT_SIZE, {32'd0, $urandom | 32'd1});
    cfg_write(REG_FILE_SIZE, {1'b0, file_cur});
    run_chunks(40, 4096);

    set_idling(3);
    file_cur = (63'd1 << 40) + {$urandom, $urandom};
    cfg_write(REG_DEFAULT_SIZE, 64'hFFFF_FFFF);
    cfg_write(REG_FILE_SIZE, {1'b0, file_cur});
    run_chunks(1000, 4096);

    // Coverage check passes once the declared count matches what was walked.
    set_idling($urandom_range(3));
    cfg_write(REG_SAMPLE_COUNT, 64'(used));
    send(FN_END, $urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
    drain();

    // One terminal error, then a few transactions to see that it stays sticky.
    kind = $urandom_range(5);
    case (kind)
      0: send(FN_MAP, $urandom | 32'd1, $urandom_range(65, 32'hFFFF_FFFF), $urandom,
              $urandom, {$urandom, $urandom});
      1: send(FN_SIZE, $urandom, $urandom, $urandom, 32'd0, {$urandom, $urandom});
      2: begin
        cfg_write(REG_SAMPLE_COUNT, $urandom_range(1) ? 64'd0 : 64'd5000);
        send(FN_CHUNK, $urandom, $urandom, $urandom, $urandom, 64'd0);
      end
      3: begin
        cfg_write(REG_SAMPLE_COUNT, 64'd4096);
        send(FN_CHUNK, $urandom, $urandom, $urandom, $urandom,
             {$urandom, $urandom} | 64'h8000_0000_0000_0000);
      end
      4: begin
        cfg_write(REG_SAMPLE_COUNT, 64'd4096);
        cfg_write(REG_FILE_SIZE, 64'd0);
        send(FN_CHUNK, $urandom, $urandom, $urandom, $urandom, 64'd0);
      end
      default: begin
        cfg_write(REG_SAMPLE_COUNT, used == 4096 ? 64'(used - 1) : 64'(used + 1));
        send(FN_END, $urandom, $urandom, $urandom, $urandom, 64'd0);
      end
    endcase
    for (int i = 0; i < 4; i++)
      send_noise(func_e_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                 {$urandom, $urandom});
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
